// File: src/dll_pkg.sv
// Shared types and codes for the doubly linked list engine.
package dll_pkg;

   localparam logic [1:0] FUNC_APPEND  = 2'd0;
   localparam logic [1:0] FUNC_PREPEND = 2'd1;
   localparam logic [1:0] FUNC_DELETE  = 2'd2;

   localparam logic [1:0] STATUS_DONE = 2'd0;
   localparam logic [1:0] STATUS_MISS = 2'd1;
   localparam logic [1:0] STATUS_FULL = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_POP_WAIT,
      ST_INS_NODE,
      ST_INS_LINK,
      ST_DEL_CHK,
      ST_DEL_FIX,
      ST_FINISH
   } dll_state_type;

   typedef struct packed {
      logic en;
      logic wr_value;
      logic wr_next;
      logic wr_prev;
   } node_wen_type;

endpackage

// File: src/dll_channels.sv
// Valid/ready channel interfaces for requests and responses.
interface dll_req_if #(
   parameter int VALUE_BITS = 32
);
   logic                         valid;
   logic                         ready;
   logic [1:0]                   func;
   logic signed [VALUE_BITS-1:0] value;

   modport source (output valid, output func, output value, input ready);
   modport sink   (input valid, input func, input value, output ready);
endinterface

interface dll_rsp_if #(
   parameter int LEN_BITS = 9
);
   logic                valid;
   logic                ready;
   logic [1:0]          status;
   logic [LEN_BITS-1:0] length;

   modport source (output valid, output status, output length, input ready);
   modport sink   (input valid, input status, input length, output ready);
endinterface

// File: src/dll_node_mem.sv
// Node pool memory: value, next and prev per node, field write enables, registered read.
module dll_node_mem #(
   parameter int POOL_DEPTH = 256,
   parameter int VALUE_BITS = 32,
   parameter int ADDR_BITS  = 8,
   parameter int PTR_BITS   = 9
) (
   input  logic                         clock,
   input  dll_pkg::node_wen_type        wen,
   input  logic [ADDR_BITS-1:0]         wr_addr,
   input  logic signed [VALUE_BITS-1:0] wr_value,
   input  logic [PTR_BITS-1:0]          wr_next,
   input  logic [PTR_BITS-1:0]          wr_prev,
   input  logic [ADDR_BITS-1:0]         rd_addr,
   output logic signed [VALUE_BITS-1:0] rd_value,
   output logic [PTR_BITS-1:0]          rd_next,
   output logic [PTR_BITS-1:0]          rd_prev
);
   import dll_pkg::*;

   logic signed [VALUE_BITS-1:0] value_mem [POOL_DEPTH];
   logic [PTR_BITS-1:0]          next_mem  [POOL_DEPTH];
   logic [PTR_BITS-1:0]          prev_mem  [POOL_DEPTH];

   always_ff @(posedge clock) begin
      if (wen.en && wen.wr_value) begin
         value_mem[wr_addr] <= wr_value;
      end
      if (wen.en && wen.wr_next) begin
         next_mem[wr_addr] <= wr_next;
      end
      if (wen.en && wen.wr_prev) begin
         prev_mem[wr_addr] <= wr_prev;
      end
      rd_value <= value_mem[rd_addr];
      rd_next  <= next_mem[rd_addr];
      rd_prev  <= prev_mem[rd_addr];
   end

endmodule

// File: src/doubly_linked_list_engine.sv
// Doubly linked list engine: node pool, free stack and list control sequencer.
//
// Usage: requests arrive on req_ch (func, value); each request yields exactly one
// beat on rsp_ch (status, length). func append/prepend inserts a value at the
// tail/head, delete unlinks the first node from the head whose value matches, and
// the unused code changes nothing. A full pool refuses inserts with status full.
// One request is in work at a time; req_ch.ready is high while the sequencer idles.
// An insert writes the new node in ST_INS_NODE and, when the list was not empty, links
//   its neighbour in ST_INS_LINK; a free node that comes from the free-stack memory rather
//   than the untouched pool region first passes ST_POP_WAIT for the stack read. A delete
//   walks from the head in ST_DEL_CHK, one node memory read per cycle, and unlinks a match
//   in ST_DEL_FIX; a miss or any other request goes on to ST_FINISH.
// A finished response waits in the output register; the next request is still
// taken meanwhile and is held at its final step until the output register frees.
// Reset (synchronous) empties the list and marks all nodes free; no clearing pass
// is needed, since untouched free-stack slots are computed from a low-water mark.
module doubly_linked_list_engine #(
   parameter int POOL_DEPTH = 256,
   parameter int VALUE_BITS = 32
) (
   input logic clock,
   input logic reset,
   dll_req_if.sink   req_ch,
   dll_rsp_if.source rsp_ch
);
   import dll_pkg::*;

   localparam int ADDR_BITS = $clog2(POOL_DEPTH);
   localparam int PTR_BITS  = $clog2(POOL_DEPTH + 1);
   localparam logic [PTR_BITS-1:0]  NIL      = PTR_BITS'(POOL_DEPTH);
   localparam logic [ADDR_BITS-1:0] LAST_IDX = ADDR_BITS'(POOL_DEPTH - 1);

   dll_state_type state_ff, state_in;

   logic [1:0]                   op_ff, op_in;
   logic signed [VALUE_BITS-1:0] val_ff, val_in;
   logic [1:0]                   status_ff, status_in;
   logic [PTR_BITS-1:0]          head_ff, head_in;
   logic [PTR_BITS-1:0]          tail_ff, tail_in;
   logic [PTR_BITS-1:0]          top_ff, top_in;
   logic [PTR_BITS-1:0]          low_ff, low_in;
   logic [PTR_BITS-1:0]          count_ff, count_in;
   logic [PTR_BITS-1:0]          cur_ff, cur_in;
   logic [PTR_BITS-1:0]          link_ff, link_in;
   logic [PTR_BITS-1:0]          p_ff, p_in;
   logic [PTR_BITS-1:0]          q_ff, q_in;
   logic [ADDR_BITS-1:0]         node_ff, node_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [1:0]                   rsp_status_ff, rsp_status_in;
   logic [PTR_BITS-1:0]          rsp_length_ff, rsp_length_in;

   logic [ADDR_BITS-1:0] stack_mem [POOL_DEPTH];
   logic [ADDR_BITS-1:0] stk_rd_ff;
   logic                 stk_we;
   logic [ADDR_BITS-1:0] stk_waddr;
   logic [ADDR_BITS-1:0] stk_wdata;
   logic [ADDR_BITS-1:0] stk_raddr;

   node_wen_type                 nwen;
   logic [ADDR_BITS-1:0]         nw_addr;
   logic signed [VALUE_BITS-1:0] nw_value;
   logic [PTR_BITS-1:0]          nw_next;
   logic [PTR_BITS-1:0]          nw_prev;
   logic [ADDR_BITS-1:0]         nr_addr;
   logic signed [VALUE_BITS-1:0] nr_value;
   logic [PTR_BITS-1:0]          nr_next;
   logic [PTR_BITS-1:0]          nr_prev;

   logic                req_fire;
   logic                req_ins;
   logic                pool_empty;
   logic                fresh;
   logic                head_ok;
   logic                match;
   logic                next_ok;
   logic                rsp_free;
   logic [PTR_BITS-1:0] top_m1;

   dll_node_mem #(
      .POOL_DEPTH (POOL_DEPTH),
      .VALUE_BITS (VALUE_BITS),
      .ADDR_BITS  (ADDR_BITS),
      .PTR_BITS   (PTR_BITS)
   ) u_node_mem (
      .clock    (clock),
      .wen      (nwen),
      .wr_addr  (nw_addr),
      .wr_value (nw_value),
      .wr_next  (nw_next),
      .wr_prev  (nw_prev),
      .rd_addr  (nr_addr),
      .rd_value (nr_value),
      .rd_next  (nr_next),
      .rd_prev  (nr_prev)
   );

   assign req_fire   = req_ch.valid && req_ch.ready;
   assign req_ins    = (req_ch.func == FUNC_APPEND) || (req_ch.func == FUNC_PREPEND);
   assign pool_empty = (top_ff == '0);
   assign top_m1     = top_ff - PTR_BITS'(1);
   assign fresh      = (top_m1 < low_ff);
   assign head_ok    = (head_ff < NIL);
   assign match      = (nr_value == val_ff);
   assign next_ok    = (nr_next < NIL);
   assign rsp_free   = !rsp_valid_ff || rsp_ch.ready;

   assign req_ch.ready  = (state_ff == ST_IDLE);
   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.status = rsp_status_ff;
   assign rsp_ch.length = rsp_length_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_ins) begin
                  if (pool_empty) begin
                     state_in = ST_FINISH;
                  end else if (fresh) begin
                     state_in = ST_INS_NODE;
                  end else begin
                     state_in = ST_POP_WAIT;
                  end
               end else if (req_ch.func == FUNC_DELETE) begin
                  state_in = head_ok ? ST_DEL_CHK : ST_FINISH;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_POP_WAIT: state_in = ST_INS_NODE;
         ST_INS_NODE: state_in = head_ok ? ST_INS_LINK : ST_FINISH;
         ST_INS_LINK: state_in = ST_FINISH;
         ST_DEL_CHK: begin
            if (match) begin
               state_in = ST_DEL_FIX;
            end else if (!next_ok) begin
               state_in = ST_FINISH;
            end
         end
         ST_DEL_FIX: state_in = ST_FINISH;
         ST_FINISH: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      op_in         = op_ff;
      val_in        = val_ff;
      status_in     = status_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      top_in        = top_ff;
      low_in        = low_ff;
      count_in      = count_ff;
      cur_in        = cur_ff;
      link_in       = link_ff;
      p_in          = p_ff;
      q_in          = q_ff;
      node_in       = node_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in = rsp_status_ff;
      rsp_length_in = rsp_length_ff;
      stk_we        = 1'b0;
      stk_waddr     = top_ff[ADDR_BITS-1:0];
      stk_wdata     = cur_ff[ADDR_BITS-1:0];
      stk_raddr     = top_m1[ADDR_BITS-1:0];
      nwen          = '0;
      nw_addr       = node_ff;
      nw_value      = val_ff;
      nw_next       = NIL;
      nw_prev       = NIL;
      nr_addr       = head_ff[ADDR_BITS-1:0];
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               op_in     = req_ch.func;
               val_in    = req_ch.value;
               status_in = STATUS_DONE;
               cur_in    = head_ff;
               if (req_ins) begin
                  if (pool_empty) begin
                     status_in = STATUS_FULL;
                  end else begin
                     top_in = top_m1;
                     if (fresh) begin
                        low_in  = top_m1;
                        node_in = LAST_IDX - top_m1[ADDR_BITS-1:0];
                     end
                  end
               end else if (req_ch.func == FUNC_DELETE && !head_ok) begin
                  status_in = STATUS_MISS;
               end
            end
         end
         ST_POP_WAIT: node_in = stk_rd_ff;
         ST_INS_NODE: begin
            nwen     = '{en: 1'b1, wr_value: 1'b1, wr_next: 1'b1, wr_prev: 1'b1};
            count_in = count_ff + PTR_BITS'(1);
            if (!head_ok) begin
               head_in = PTR_BITS'(node_ff);
               tail_in = PTR_BITS'(node_ff);
            end else if (op_ff == FUNC_PREPEND) begin
               nw_next = head_ff;
               link_in = head_ff;
               head_in = PTR_BITS'(node_ff);
            end else begin
               nw_prev = tail_ff;
               link_in = tail_ff;
               tail_in = PTR_BITS'(node_ff);
            end
         end
         ST_INS_LINK: begin
            nw_addr = link_ff[ADDR_BITS-1:0];
            if (op_ff == FUNC_PREPEND) begin
               nwen    = '{en: 1'b1, wr_value: 1'b0, wr_next: 1'b0, wr_prev: 1'b1};
               nw_prev = PTR_BITS'(node_ff);
            end else begin
               nwen    = '{en: 1'b1, wr_value: 1'b0, wr_next: 1'b1, wr_prev: 1'b0};
               nw_next = PTR_BITS'(node_ff);
            end
         end
         ST_DEL_CHK: begin
            if (match) begin
               p_in = nr_prev;
               q_in = nr_next;
               if (nr_prev < NIL) begin
                  nwen    = '{en: 1'b1, wr_value: 1'b0, wr_next: 1'b1, wr_prev: 1'b0};
                  nw_addr = nr_prev[ADDR_BITS-1:0];
                  nw_next = nr_next;
               end else begin
                  head_in = nr_next;
               end
            end else if (next_ok) begin
               cur_in  = nr_next;
               nr_addr = nr_next[ADDR_BITS-1:0];
            end else begin
               status_in = STATUS_MISS;
            end
         end
         ST_DEL_FIX: begin
            if (q_ff < NIL) begin
               nwen    = '{en: 1'b1, wr_value: 1'b0, wr_next: 1'b0, wr_prev: 1'b1};
               nw_addr = q_ff[ADDR_BITS-1:0];
               nw_prev = p_ff;
            end else begin
               tail_in = p_ff;
            end
            stk_we   = 1'b1;
            top_in   = top_ff + PTR_BITS'(1);
            count_in = count_ff - PTR_BITS'(1);
         end
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_length_in = count_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= NIL;
         tail_ff      <= NIL;
         top_ff       <= PTR_BITS'(POOL_DEPTH);
         low_ff       <= PTR_BITS'(POOL_DEPTH);
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         top_ff       <= top_in;
         low_ff       <= low_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      val_ff        <= val_in;
      status_ff     <= status_in;
      cur_ff        <= cur_in;
      link_ff       <= link_in;
      p_ff          <= p_in;
      q_ff          <= q_in;
      node_ff       <= node_in;
      rsp_status_ff <= rsp_status_in;
      rsp_length_ff <= rsp_length_in;
   end

   // free stack: slots below the low-water mark were never written
   always_ff @(posedge clock) begin
      if (stk_we) begin
         stack_mem[stk_waddr] <= stk_wdata;
      end
      stk_rd_ff <= stack_mem[stk_raddr];
   end

`ifndef SYNTHESIS
   a_pool_balance: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |->
         ({1'b0, count_ff} + {1'b0, top_ff} == (PTR_BITS + 1)'(POOL_DEPTH)))
      else $error("node count and free stack out of balance");

   a_head_vs_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> ((head_ff < NIL) == (count_ff != '0)))
      else $error("head index disagrees with node count");

   a_full_length: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == STATUS_FULL) |->
         (rsp_length_ff == PTR_BITS'(POOL_DEPTH)))
      else $error("pool full reported with free nodes left");
`endif

endmodule

// File: verif/testbench.sv
// Self-checking testbench for the doubly linked list engine.
module testbench;
   import dll_pkg::*;

   localparam int POOL_DEPTH = 256;
   localparam int VALUE_BITS = 32;
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   typedef struct packed {
      logic [1:0] status;
      logic [8:0] length;
   } rsp_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   dll_req_if #(.VALUE_BITS(VALUE_BITS)) req_ch ();
   dll_rsp_if #(.LEN_BITS(9))             rsp_ch ();

   doubly_linked_list_engine #(
      .POOL_DEPTH(POOL_DEPTH),
      .VALUE_BITS(VALUE_BITS)
   ) dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch.sink),
      .rsp_ch(rsp_ch.source)
   );

   logic signed [VALUE_BITS-1:0] list_model[$];
   rsp_beat_type                 pending_rsp[$];
   int                           fail_count;
   int                           send_idle_pct;
   int                           rsp_stall_pct;

   always #5 clock = ~clock;

   initial begin
      req_ch.valid = 1'b0;
      req_ch.func  = FUNC_APPEND;
      req_ch.value = '0;
      rsp_ch.ready = 1'b0;
      fail_count    = 0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
   end

   always @(negedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // list order after each request, kept as a plain queue of values
   function automatic rsp_beat_type apply_request(logic [1:0] func,
                                                  logic signed [VALUE_BITS-1:0] value);
      rsp_beat_type r;
      int           hit;
      r.status = STATUS_DONE;
      hit      = -1;
      case (func)
         FUNC_APPEND, FUNC_PREPEND: begin
            if (list_model.size() >= POOL_DEPTH) begin
               r.status = STATUS_FULL;
            end else if (func == FUNC_APPEND) begin
               list_model.push_back(value);
            end else begin
               list_model.push_front(value);
            end
         end
         FUNC_DELETE: begin
            foreach (list_model[i]) begin
               if (hit < 0 && list_model[i] == value) hit = i;
            end
            if (hit < 0) begin
               r.status = STATUS_MISS;
            end else begin
               list_model.delete(hit);
            end
         end
         default: ;
      endcase
      r.length = 9'(list_model.size());
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_beat_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_rsp.size() == 0) begin
            fail_count++;
            $display("%0t: unexpected response status %0d length %0d",
                     $time, rsp_ch.status, rsp_ch.length);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_ch.status !== want.status) begin
               fail_count++;
               $display("%0t: status expected %0d actual %0d",
                        $time, want.status, rsp_ch.status);
            end
            if (rsp_ch.length !== want.length) begin
               fail_count++;
               $display("%0t: length expected %0d actual %0d",
                        $time, want.length, rsp_ch.length);
            end
         end
      end
   end

   // called at a falling edge; returns at the falling edge after the beat
   task automatic send_request(input logic [1:0] func,
                               input logic signed [VALUE_BITS-1:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.func  <= func;
      req_ch.value <= value;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      pending_rsp.push_back(apply_request(func, value));
      @(negedge clock);
   endtask

   task automatic wait_for_responses();
      req_ch.valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic test_directed();
      send_request(FUNC_DELETE, 32'sd5);
      send_request(FUNC_UNUSED, 32'sd0);
      send_request(FUNC_APPEND, 32'sh8000_0000);
      send_request(FUNC_APPEND, 32'sh7FFF_FFFF);
      send_request(FUNC_PREPEND, 32'sd0);
      send_request(FUNC_PREPEND, -32'sd1);
      send_request(FUNC_APPEND, 32'sd7);
      send_request(FUNC_APPEND, 32'sd7);
      send_request(FUNC_PREPEND, 32'sd7);
      send_request(FUNC_DELETE, 32'sd7);
      send_request(FUNC_DELETE, 32'sd123);
      send_request(FUNC_UNUSED, -32'sd1);
      send_request(FUNC_DELETE, 32'sh7FFF_FFFF);
      send_request(FUNC_DELETE, 32'sd7);
      send_request(FUNC_DELETE, 32'sd7);
      send_request(FUNC_DELETE, -32'sd1);
      send_request(FUNC_DELETE, 32'sh8000_0000);
      send_request(FUNC_DELETE, 32'sd0);
      send_request(FUNC_DELETE, 32'sd0);
      send_request(FUNC_PREPEND, 32'sh5555_5555);
      send_request(FUNC_DELETE, 32'sh5555_5555);
      send_request(FUNC_APPEND, 32'shAAAA_AAAA);
      send_request(FUNC_PREPEND, 32'sd2);
      send_request(FUNC_DELETE, 32'shAAAA_AAAA);
      send_request(FUNC_DELETE, 32'sd2);
   endtask

   task automatic test_pool_full();
      logic signed [VALUE_BITS-1:0] v;
      for (int i = 0; i < POOL_DEPTH; i++) begin
         v = (i % 3 == 0) ? $signed(32'($urandom_range(7))) : $signed($urandom);
         send_request((i % 2 == 0) ? FUNC_APPEND : FUNC_PREPEND, v);
      end
      send_request(FUNC_APPEND, 32'sd99);
      send_request(FUNC_PREPEND, 32'sd99);
      send_request(FUNC_DELETE, list_model[POOL_DEPTH / 2]);
      send_request(FUNC_APPEND, 32'sd100);
      send_request(FUNC_APPEND, 32'sd101);
      send_request(FUNC_PREPEND, 32'sd102);
      // tail match forces the longest walk
      send_request(FUNC_DELETE, list_model[list_model.size() - 1]);
      while (list_model.size() != 0) begin
         send_request(FUNC_DELETE, list_model[$urandom_range(list_model.size() - 1)]);
      end
   endtask

   task automatic test_random_traffic(input int count, input int idle_pct,
                                      input int stall_pct);
      int                           roll;
      int                           insert_pct;
      logic [1:0]                   func;
      logic signed [VALUE_BITS-1:0] v;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      for (int n = 0; n < count; n++) begin
         roll = $urandom_range(99);
         if (list_model.size() < 8)       insert_pct = 70;
         else if (list_model.size() > 48) insert_pct = 30;
         else                             insert_pct = 50;
         if (roll < 3) begin
            func = FUNC_UNUSED;
            v    = $signed($urandom);
         end else if (roll < 3 + insert_pct) begin
            func = ($urandom_range(1) == 0) ? FUNC_APPEND : FUNC_PREPEND;
            v    = ($urandom_range(1) == 0) ? $signed(32'($urandom_range(15)) - 32'd8)
                                            : $signed($urandom);
         end else begin
            func = FUNC_DELETE;
            roll = $urandom_range(99);
            if (list_model.size() == 0 || roll < 15) begin
               v = $signed($urandom);
            end else begin
               v = list_model[$urandom_range(list_model.size() - 1)];
               // near miss: one bit off a stored value
               if (roll < 30) v = v ^ (32'sd1 << $urandom_range(VALUE_BITS - 1));
            end
         end
         send_request(func, v);
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed();
      wait_for_responses();
      send_idle_pct = 36;
      rsp_stall_pct = 36;
      test_pool_full();
      wait_for_responses();
      test_random_traffic(340, 0, 0);
      test_random_traffic(340, 83, 0);
      wait_for_responses();
      test_random_traffic(340, 0, 83);
      test_random_traffic(340, 36, 36);
      wait_for_responses();

      repeat (POOL_DEPTH + 8) @(posedge clock);
      if (pending_rsp.size() != 0) begin
         fail_count++;
         $display("%0t: %0d responses never arrived", $time, pending_rsp.size());
      end
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #40_000_000;
      $display("%0t: timeout", $time);
      $display("== FAIL ==");
      $finish;
   end

endmodule
